// ----- sv/mbs_pkg.sv -----
// Shared types, widths and codes of the mesh bounding sphere unit.
package mbs_pkg;

    localparam int COORD_W         = 16;
    localparam int RADIUS_W        = 15;
    localparam int CFG_IDX_W       = 2;
    localparam int DIST_W          = 16;   // |vertex - anchor| per axis
    localparam int SQ_W            = 2 * DIST_W;
    localparam int HALF_W          = 15;   // truncated half-extent
    localparam int HSQ_W           = 2 * HALF_W;
    localparam int FAR_W           = SQ_W + 2;
    localparam int HSUM_W          = HSQ_W + 2;
    localparam int RAD_W           = 36;   // radicand, even width
    localparam int ROOT_W          = RAD_W / 2;
    localparam int REM_W           = ROOT_W + 3;
    localparam int ITER_W          = $clog2(ROOT_W);
    localparam int QUEUE_DEPTH_DEF = 2;

    typedef logic signed [COORD_W-1:0] coord_t;

    localparam coord_t COORD_MAX = coord_t'(16'sh7FFF);
    localparam coord_t COORD_MIN = coord_t'(16'sh8000);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_EN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_X  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_Y  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_Z  = 2'd3;

    typedef struct packed {
        logic   anchor_en;
        coord_t anchor_x;
        coord_t anchor_y;
        coord_t anchor_z;
    } cfg_t;

    // One finished object waiting for its square root
    typedef struct packed {
        coord_t           center_x;
        coord_t           center_y;
        coord_t           center_z;
        logic [RAD_W-1:0] radicand;
    } job_t;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_CALC,
        SQ_HOLD
    } sqrt_state_t;

endpackage

// ----- sv/mbs_front.sv -----
// Front part: vertex accumulation (min/max and farthest distance) and job build.
module mbs_front #(
    parameter int DEPTH = mbs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push_acc,
    input  logic signed [mbs_pkg::COORD_W-1:0] vert_x,
    input  logic signed [mbs_pkg::COORD_W-1:0] vert_y,
    input  logic signed [mbs_pkg::COORD_W-1:0] vert_z,
    input  logic                          last_vertex,
    input  mbs_pkg::cfg_t                 cfg,
    input  logic                          job_pop,
    output logic                          full,
    output logic                          job_push,
    output mbs_pkg::job_t                 job
);
    import mbs_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    coord_t vin [3];
    coord_t anc [3];

    // Running accumulators
    coord_t           min_reg [3];
    coord_t           max_reg [3];
    logic [FAR_W-1:0] far_reg;
    logic [CNT_W-1:0] pend_reg;

    // Stage A
    logic              a_vld_reg;
    logic              a_last_reg;
    logic              a_en_reg;
    logic [DIST_W-1:0] a_dist_reg [3];
    coord_t            a_min_reg  [3];
    coord_t            a_max_reg  [3];
    coord_t            a_anc_reg  [3];

    // Stage B
    logic              b_vld_reg;
    logic              b_last_reg;
    logic              b_en_reg;
    logic [SQ_W-1:0]   b_sq_reg   [3];
    logic [HSQ_W-1:0]  b_hsq_reg  [3];
    coord_t            b_ctr_reg  [3];

    logic [FAR_W-1:0]  sum_sq;
    logic [FAR_W-1:0]  far_next;
    logic [HSUM_W-1:0] sum_hsq;

    assign vin[0] = vert_x;
    assign vin[1] = vert_y;
    assign vin[2] = vert_z;
    assign anc[0] = cfg.anchor_x;
    assign anc[1] = cfg.anchor_y;
    assign anc[2] = cfg.anchor_z;

    // Track outstanding objects so the job queue never overflows
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_reg + CNT_W'(push_acc && last_vertex) - CNT_W'(job_pop);
        end
    end

    assign full = (pend_reg == CNT_W'(DEPTH));

    // Stage A and stage B valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= push_acc;
            b_vld_reg <= a_vld_reg;
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_axis
        logic signed [COORD_W:0] diff;
        logic [COORD_W:0]        dmag;
        coord_t                  nmin;
        coord_t                  nmax;
        logic signed [COORD_W:0] ext;
        logic signed [COORD_W:0] mid;
        logic [HALF_W-1:0]       half;

        // Absolute distance to the anchor and updated extremes
        assign diff = {vin[i][COORD_W-1], vin[i]} - {anc[i][COORD_W-1], anc[i]};
        assign dmag = diff[COORD_W] ? (~diff + 1'b1) : diff;
        assign nmin = (vin[i] < min_reg[i]) ? vin[i] : min_reg[i];
        assign nmax = (vin[i] > max_reg[i]) ? vin[i] : max_reg[i];

        // Update extremes; restart them after the last vertex
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                min_reg[i] <= COORD_MAX;
                max_reg[i] <= COORD_MIN;
            end
            else if (push_acc)
            begin
                min_reg[i] <= last_vertex ? COORD_MAX : nmin;
                max_reg[i] <= last_vertex ? COORD_MIN : nmax;
            end
        end

        // Capture stage A payload
        always_ff @(posedge clk)
        begin
            if (push_acc)
            begin
                a_dist_reg[i] <= dmag[DIST_W-1:0];
                a_min_reg[i]  <= nmin;
                a_max_reg[i]  <= nmax;
                a_anc_reg[i]  <= anc[i];
            end
        end

        // Midpoint truncated toward zero, half-extent truncated
        assign ext  = {a_max_reg[i][COORD_W-1], a_max_reg[i]}
                    - {a_min_reg[i][COORD_W-1], a_min_reg[i]};
        assign mid  = {a_max_reg[i][COORD_W-1], a_max_reg[i]}
                    + {a_min_reg[i][COORD_W-1], a_min_reg[i]}
                    + {{COORD_W{1'b0}}, (a_max_reg[i][COORD_W-1] ^ ~a_min_reg[i][COORD_W-1])
                       ? 1'b0 : 1'b0};
        assign half = ext[HALF_W:1];

        // Squares and centers into stage B
        always_ff @(posedge clk)
        begin
            if (a_vld_reg)
            begin
                b_sq_reg[i]  <= SQ_W'(a_dist_reg[i]) * SQ_W'(a_dist_reg[i]);
                b_hsq_reg[i] <= HSQ_W'(half) * HSQ_W'(half);
                b_ctr_reg[i] <= a_en_reg ? a_anc_reg[i]
                                         : coord_t'((mid + {{COORD_W{1'b0}}, mid[COORD_W]})
                                                    >>> 1);
            end
        end
    end

    // Capture per-item flags
    always_ff @(posedge clk)
    begin
        if (push_acc)
        begin
            a_last_reg <= last_vertex;
            a_en_reg   <= cfg.anchor_en;
        end
        if (a_vld_reg)
        begin
            b_last_reg <= a_last_reg;
            b_en_reg   <= a_en_reg;
        end
    end

    // Sum squared distances and keep the largest
    assign sum_sq   = FAR_W'(b_sq_reg[0]) + FAR_W'(b_sq_reg[1]) + FAR_W'(b_sq_reg[2]);
    assign sum_hsq  = HSUM_W'(b_hsq_reg[0]) + HSUM_W'(b_hsq_reg[1]) + HSUM_W'(b_hsq_reg[2]);
    assign far_next = (sum_sq > far_reg) ? sum_sq : far_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            far_reg <= '0;
        end
        else if (b_vld_reg)
        begin
            far_reg <= b_last_reg ? '0 : far_next;
        end
    end

    // Issue one job per object
    assign job_push     = b_vld_reg && b_last_reg;
    assign job.center_x = b_ctr_reg[0];
    assign job.center_y = b_ctr_reg[1];
    assign job.center_z = b_ctr_reg[2];
    assign job.radicand = b_en_reg ? RAD_W'(far_next) : RAD_W'(sum_hsq);

endmodule

// ----- sv/mbs_job_queue.sv -----
// Short job queue between the accumulation front and the square root back.
module mbs_job_queue #(
    parameter int DEPTH = mbs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  mbs_pkg::job_t wr_job,
    input  logic          rd_en,
    output mbs_pkg::job_t rd_job,
    output logic          empty
);
    import mbs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + CNT_W'(wr_en) - CNT_W'(rd_en);
        end
    end

    // Store the request
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_job;
        end
    end

    assign rd_job = slot_reg[rd_ptr_reg];
    assign empty  = (cnt_reg == '0);

endmodule

// ----- sv/mbs_sqrt_back.sv -----
// Back part: bit-serial floor square root, radius clipping and result register.
module mbs_sqrt_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_empty,
    input  mbs_pkg::job_t                       q_job,
    output logic                                q_pop,
    input  logic                                pop,
    output logic                                empty,
    output logic signed [mbs_pkg::COORD_W-1:0]  center_x,
    output logic signed [mbs_pkg::COORD_W-1:0]  center_y,
    output logic signed [mbs_pkg::COORD_W-1:0]  center_z,
    output logic [mbs_pkg::RADIUS_W-1:0]        sphere_radius,
    output logic                                radius_clipped
);
    import mbs_pkg::*;

    sqrt_state_t       st_reg,   st_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic [RAD_W-1:0]  rad_reg,  rad_next;
    logic [REM_W-1:0]  rem_reg,  rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    coord_t            cx_reg, cx_next, cy_reg, cy_next, cz_reg, cz_next;

    logic              ovld_reg, ovld_next;
    coord_t            ox_reg, ox_next, oy_reg, oy_next, oz_reg, oz_next;
    logic [RADIUS_W-1:0] orad_reg, orad_next;
    logic              oclip_reg, oclip_next;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              out_free;
    logic              clip;

    assign rem_sh   = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign trial    = REM_W'({root_reg, 2'b01});
    assign out_free = !ovld_reg || pop;
    assign clip     = (root_reg[ROOT_W-1:RADIUS_W] != '0);

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= SQ_IDLE;
            ovld_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            ovld_reg <= ovld_next;
        end
    end

    // Hold datapath registers
    always_ff @(posedge clk)
    begin
        iter_reg  <= iter_next;
        rad_reg   <= rad_next;
        rem_reg   <= rem_next;
        root_reg  <= root_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        cz_reg    <= cz_next;
        ox_reg    <= ox_next;
        oy_reg    <= oy_next;
        oz_reg    <= oz_next;
        orad_reg  <= orad_next;
        oclip_reg <= oclip_next;
    end

    // Load a job, resolve one root digit per cycle, then hand off the result
    always_comb
    begin
        st_next    = st_reg;
        iter_next  = iter_reg;
        rad_next   = rad_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        cz_next    = cz_reg;
        ovld_next  = ovld_reg && !pop;
        ox_next    = ox_reg;
        oy_next    = oy_reg;
        oz_next    = oz_reg;
        orad_next  = orad_reg;
        oclip_next = oclip_reg;
        q_pop      = 1'b0;

        case (st_reg)
            SQ_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop     = 1'b1;
                    rad_next  = q_job.radicand;
                    cx_next   = q_job.center_x;
                    cy_next   = q_job.center_y;
                    cz_next   = q_job.center_z;
                    rem_next  = '0;
                    root_next = '0;
                    iter_next = '0;
                    st_next   = SQ_CALC;
                end
            end
            SQ_CALC:
            begin
                rad_next = {rad_reg[RAD_W-3:0], 2'b00};
                if (rem_sh >= trial)
                begin
                    rem_next  = rem_sh - trial;
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh;
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                iter_next = iter_reg + 1'b1;
                if (iter_reg == ITER_W'(ROOT_W - 1))
                begin
                    st_next = SQ_HOLD;
                end
            end
            SQ_HOLD:
            begin
                if (out_free)
                begin
                    ovld_next  = 1'b1;
                    ox_next    = cx_reg;
                    oy_next    = cy_reg;
                    oz_next    = cz_reg;
                    orad_next  = clip ? {RADIUS_W{1'b1}} : root_reg[RADIUS_W-1:0];
                    oclip_next = clip;
                    st_next    = SQ_IDLE;
                end
            end
            default:
            begin
                st_next = SQ_IDLE;
            end
        endcase
    end

    assign empty          = !ovld_reg;
    assign center_x       = ox_reg;
    assign center_y       = oy_reg;
    assign center_z       = oz_reg;
    assign sphere_radius  = orad_reg;
    assign radius_clipped = oclip_reg;

endmodule

// ----- sv/mesh_bounding_sphere_unit.sv -----
// Top level of the mesh bounding sphere unit: config registers and part wiring.
//
//  channel   direction  handshake             payload
//  vertex    in         push / full           vert_x, vert_y, vert_z, last_vertex
//  result    out        empty / pop           center_x/y/z, sphere_radius, radius_clipped
//  config    in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// Vertices are taken one per cycle; full rises only when QDEPTH objects are pending.
// An object passes front stages A and B and the job queue, then the square root
// unit, which loads the request, resolves one root bit per cycle and registers the
// result, one object at a time. Reset clears all accumulators and config.
// A held result stalls the root unit; the front keeps taking vertices until QDEPTH
// objects wait for the root unit.
module mesh_bounding_sphere_unit #(
    parameter int QDEPTH = mbs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic signed [mbs_pkg::COORD_W-1:0]   vert_x,
    input  logic signed [mbs_pkg::COORD_W-1:0]   vert_y,
    input  logic signed [mbs_pkg::COORD_W-1:0]   vert_z,
    input  logic                                 last_vertex,
    output logic                                 empty,
    input  logic                                 pop,
    output logic signed [mbs_pkg::COORD_W-1:0]   center_x,
    output logic signed [mbs_pkg::COORD_W-1:0]   center_y,
    output logic signed [mbs_pkg::COORD_W-1:0]   center_z,
    output logic [mbs_pkg::RADIUS_W-1:0]         sphere_radius,
    output logic                                 radius_clipped,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mbs_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [mbs_pkg::COORD_W-1:0]          cfg_data
);
    import mbs_pkg::*;

    cfg_t cfg_reg;
    logic push_acc;
    logic job_push;
    job_t job_in;
    job_t job_head;
    logic q_empty;
    logic q_pop;

    assign cfg_ready = 1'b1;
    assign push_acc  = push && !full;

    // Write config registers on each request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_ANCHOR_EN: cfg_reg.anchor_en <= cfg_data[0];
                REG_ANCHOR_X:  cfg_reg.anchor_x  <= coord_t'(cfg_data);
                REG_ANCHOR_Y:  cfg_reg.anchor_y  <= coord_t'(cfg_data);
                REG_ANCHOR_Z:  cfg_reg.anchor_z  <= coord_t'(cfg_data);
                default:       cfg_reg           <= cfg_reg;
            endcase
        end
    end

    mbs_front #(
        .DEPTH (QDEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_acc    (push_acc),
        .vert_x      (vert_x),
        .vert_y      (vert_y),
        .vert_z      (vert_z),
        .last_vertex (last_vertex),
        .cfg         (cfg_reg),
        .job_pop     (q_pop),
        .full        (full),
        .job_push    (job_push),
        .job         (job_in)
    );

    mbs_job_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (job_push),
        .wr_job (job_in),
        .rd_en  (q_pop),
        .rd_job (job_head),
        .empty  (q_empty)
    );

    mbs_sqrt_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .q_job          (job_head),
        .q_pop          (q_pop),
        .pop            (pop),
        .empty          (empty),
        .center_x       (center_x),
        .center_y       (center_y),
        .center_z       (center_z),
        .sphere_radius  (sphere_radius),
        .radius_clipped (radius_clipped)
    );

endmodule
